// ----- rtl/core/mfe_pkg.sv -----
// Shared types, widths and register codes of the multipole field and force evaluator.
// Used by every module under rtl/core; depends on nothing else.
package mfe_pkg;

  // Port and field widths.
  localparam int POS_W       = 24;
  localparam int VEL_W       = 24;
  localparam int CHARGE_W    = 16;
  localparam int DROP_W      = 4;
  localparam int SCALE_W     = 32;
  localparam int TERMS_W     = 3;
  localparam int COEF_W      = 48;
  localparam int COEF_HALF_W = 24;
  localparam int FIELD_W     = 32;
  localparam int FORCE_W     = 48;

  // Internal number formats.
  localparam int POW_W   = 39;                 // powers of z, Q17.21
  localparam int SUM_W   = 48;                 // unsaturated sum of terms
  localparam int QB_W    = 34;                 // q * B after the Q.14 shift
  localparam int MUL_A_W = POW_W;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 1;

  localparam int FRAC_SHIFT   = 21;
  localparam int CHARGE_SHIFT = 14;
  localparam int VEL_SHIFT    = 22;

  // Term counting.
  localparam int TERM_W        = 4;
  localparam int MAX_TERMS_DEF = 6;
  localparam int NUM_COEF_REGS = 6;

  // Configuration port and register indexes.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_SCALE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TERMS       = 4'd1;
  localparam int                   REG_COEF_0      = 2;

  typedef enum logic [2:0] {
    A_PR, A_PI, A_SR, A_SI, A_BY, A_BX, A_QBY, A_QBX
  } a_sel_t;

  typedef enum logic [3:0] {
    B_CR, B_CI, B_X, B_Y, B_SCALE, B_Q, B_VX, B_VY, B_VZ
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_LOAD, ACC_LOAD_NEG, ACC_ADD, ACC_SUB
  } acc_mode_t;

  typedef enum logic [3:0] {
    WB_NONE, WB_SR, WB_SI, WB_PR, WB_PI, WB_BY, WB_BX,
    WB_QBY, WB_QBX, WB_FX, WB_FY, WB_FZ
  } wb_t;

  // One step for the shared multiply-accumulate unit.
  typedef struct packed {
    logic      vld;
    a_sel_t    a_sel;
    b_sel_t    b_sel;
    acc_mode_t mode;
    wb_t       wb;
  } uop_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

endpackage

// ----- rtl/core/multipole_field_and_force_eval.sv -----
// One word in flight: a new word is taken only after the result of the last one has been
// loaded into the output register. T = min(terms_in_use, MAX_TERMS) terms are run through
// the single shared multiplier, ten steps per term (eight products and two for the power
// write-back), then twelve steps for field scaling and forces.
// Reset (rst_n, synchronous, active low) stalls the input, clears the sequencer and the
// output valid and restores field_scale = 0, terms_in_use = 1 and all coefficients to zero.
module multipole_field_and_force_eval #(
  parameter int MAX_TERMS = mfe_pkg::MAX_TERMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mfe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mfe_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mfe_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [mfe_pkg::POS_W-1:0]    in_pos_y,
  input  logic signed [mfe_pkg::DROP_W-1:0]   in_drop_through,
  input  logic signed [mfe_pkg::VEL_W-1:0]    in_vel_x,
  input  logic signed [mfe_pkg::VEL_W-1:0]    in_vel_y,
  input  logic signed [mfe_pkg::VEL_W-1:0]    in_vel_z,
  input  logic signed [mfe_pkg::CHARGE_W-1:0] in_charge,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mfe_pkg::FIELD_W-1:0]  out_field_x,
  output logic signed [mfe_pkg::FIELD_W-1:0]  out_field_y,
  output logic signed [mfe_pkg::FORCE_W-1:0]  out_force_x,
  output logic signed [mfe_pkg::FORCE_W-1:0]  out_force_y,
  output logic signed [mfe_pkg::FORCE_W-1:0]  out_force_z
);

  logic                                accept;
  logic                                out_free;
  logic                                out_load;
  mfe_pkg::uop_t                       uop;
  mfe_pkg::seq_stat_t                  stat;
  logic [mfe_pkg::TERM_W-1:0]          term_idx;
  logic [mfe_pkg::COEF_W-1:0]          coef_word;
  logic signed [mfe_pkg::SCALE_W-1:0]  field_scale;
  logic [mfe_pkg::TERMS_W-1:0]         terms_in_use;
  logic signed [mfe_pkg::FIELD_W-1:0]  bx, by;
  logic signed [mfe_pkg::FORCE_W-1:0]  fx, fy, fz;

  logic                                out_valid_r;
  logic signed [mfe_pkg::FIELD_W-1:0]  out_bx_r, out_by_r;
  logic signed [mfe_pkg::FORCE_W-1:0]  out_fx_r, out_fy_r, out_fz_r;

  assign in_stall = !stat.idle || !rst_n;
  assign accept   = in_valid && !in_stall;
  // The output register is free when empty or when its word leaves this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = stat.done && out_free;

  mfe_cfg_regs #(.MAX_TERMS(MAX_TERMS)) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rd_term      (term_idx),
    .coef_rd      (coef_word),
    .field_scale  (field_scale),
    .terms_in_use (terms_in_use)
  );

  mfe_seq #(.MAX_TERMS(MAX_TERMS)) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .drop_through (in_drop_through),
    .terms_in_use (terms_in_use),
    .out_free     (out_free),
    .uop          (uop),
    .term_idx     (term_idx),
    .stat         (stat)
  );

  mfe_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (accept),
    .pos_x       (in_pos_x),
    .pos_y       (in_pos_y),
    .vel_x       (in_vel_x),
    .vel_y       (in_vel_y),
    .vel_z       (in_vel_z),
    .charge      (in_charge),
    .field_scale (field_scale),
    .coef_word   (coef_word),
    .uop         (uop),
    .field_x     (bx),
    .field_y     (by),
    .force_x     (fx),
    .force_y     (fy),
    .force_z     (fz)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bx_r <= bx;
      out_by_r <= by;
      out_fx_r <= fx;
      out_fy_r <= fy;
      out_fz_r <= fz;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_field_x = out_bx_r;
  assign out_field_y = out_by_r;
  assign out_force_x = out_fx_r;
  assign out_force_y = out_fy_r;
  assign out_force_z = out_fz_r;

endmodule

// ----- rtl/core/mfe_cfg_regs.sv -----
// Configuration registers: field scale, term count and the coefficient bank.
// Depends on mfe_pkg.
module mfe_cfg_regs #(
  parameter int MAX_TERMS = mfe_pkg::MAX_TERMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mfe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mfe_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [mfe_pkg::TERM_W-1:0]        rd_term,
  output logic [mfe_pkg::COEF_W-1:0]        coef_rd,
  output logic signed [mfe_pkg::SCALE_W-1:0] field_scale,
  output logic [mfe_pkg::TERMS_W-1:0]       terms_in_use
);

  localparam int NCOEF = (MAX_TERMS < mfe_pkg::NUM_COEF_REGS) ? MAX_TERMS
                                                              : mfe_pkg::NUM_COEF_REGS;

  logic signed [mfe_pkg::SCALE_W-1:0] scale_r;
  logic [mfe_pkg::TERMS_W-1:0]        terms_r;
  logic [mfe_pkg::COEF_W-1:0]         coef_r [NCOEF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= '0;
      terms_r <= mfe_pkg::TERMS_W'(1);
      for (int i = 0; i < NCOEF; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == mfe_pkg::REG_FIELD_SCALE) begin
        scale_r <= cfg_data[mfe_pkg::SCALE_W-1:0];
      end
      if (cfg_index == mfe_pkg::REG_TERMS) begin
        terms_r <= cfg_data[mfe_pkg::TERMS_W-1:0];
      end
      // Coefficient registers without a storage slot are simply dropped.
      for (int i = 0; i < NCOEF; i++) begin
        if (cfg_index == mfe_pkg::CFG_IDX_W'(mfe_pkg::REG_COEF_0 + i)) begin
          coef_r[i] <= cfg_data[mfe_pkg::COEF_W-1:0];
        end
      end
    end
  end

  // Terms beyond the bank read as zero.
  always_comb begin
    coef_rd = '0;
    for (int i = 0; i < NCOEF; i++) begin
      if (rd_term == mfe_pkg::TERM_W'(i)) begin
        coef_rd = coef_r[i];
      end
    end
  end

  assign field_scale  = scale_r;
  assign terms_in_use = terms_r;

endmodule

// ----- rtl/core/mfe_seq.sv -----
// Step sequencer for the shared multiply-accumulate unit: per-term steps, then the
// field scaling and force steps. Depends on mfe_pkg.
module mfe_seq #(
  parameter int MAX_TERMS = mfe_pkg::MAX_TERMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [mfe_pkg::DROP_W-1:0]    drop_through,
  input  logic [mfe_pkg::TERMS_W-1:0]   terms_in_use,
  input  logic                          out_free,
  output mfe_pkg::uop_t                 uop,
  output logic [mfe_pkg::TERM_W-1:0]    term_idx,
  output mfe_pkg::seq_stat_t            stat
);

  typedef enum logic [1:0] {S_IDLE, S_TERM, S_TAIL, S_DONE} state_t;

  // Steps of one term. The two bubbles at the end let the new power settle.
  localparam logic [3:0] ST_SR_A   = 4'd0;
  localparam logic [3:0] ST_SR_B   = 4'd1;
  localparam logic [3:0] ST_SI_A   = 4'd2;
  localparam logic [3:0] ST_SI_B   = 4'd3;
  localparam logic [3:0] ST_PR_A   = 4'd4;
  localparam logic [3:0] ST_PR_B   = 4'd5;
  localparam logic [3:0] ST_PI_A   = 4'd6;
  localparam logic [3:0] ST_PI_B   = 4'd7;
  localparam logic [3:0] ST_END    = 4'd9;
  // Steps after the last term.
  localparam logic [3:0] TL_BY     = 4'd0;
  localparam logic [3:0] TL_BX     = 4'd1;
  localparam logic [3:0] TL_QBY    = 4'd3;
  localparam logic [3:0] TL_QBX    = 4'd4;
  localparam logic [3:0] TL_FX     = 4'd6;
  localparam logic [3:0] TL_FY     = 4'd7;
  localparam logic [3:0] TL_FZ_A   = 4'd8;
  localparam logic [3:0] TL_FZ_B   = 4'd9;
  localparam logic [3:0] TL_END    = 4'd11;

  state_t                      state_r;
  logic [3:0]                  step_r;
  logic [mfe_pkg::TERM_W-1:0]  n_r;
  logic [mfe_pkg::TERM_W-1:0]  start_r;
  logic [mfe_pkg::TERM_W-1:0]  terms_r;
  logic [mfe_pkg::TERM_W-1:0]  start_nxt;
  logic [mfe_pkg::TERM_W-1:0]  terms_eff;
  logic                        drop_low;
  logic                        term_on;

  // Drop values below minus one behave as minus one.
  assign drop_low  = drop_through[mfe_pkg::DROP_W-1] && (drop_through != '1);
  assign start_nxt = drop_low ? '0 :
                     mfe_pkg::TERM_W'(drop_through) + mfe_pkg::TERM_W'(1);
  assign terms_eff = (mfe_pkg::TERM_W'(terms_in_use) > mfe_pkg::TERM_W'(MAX_TERMS)) ?
                     mfe_pkg::TERM_W'(MAX_TERMS) : mfe_pkg::TERM_W'(terms_in_use);
  assign term_on   = (n_r >= start_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      n_r     <= '0;
      start_r <= '0;
      terms_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            start_r <= start_nxt;
            terms_r <= terms_eff;
            n_r     <= '0;
            step_r  <= '0;
            state_r <= (terms_eff == '0) ? S_TAIL : S_TERM;
          end
        end
        S_TERM: begin
          if (step_r == ST_END) begin
            step_r <= '0;
            if (n_r == terms_r - mfe_pkg::TERM_W'(1)) begin
              state_r <= S_TAIL;
            end else begin
              n_r <= n_r + mfe_pkg::TERM_W'(1);
            end
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        S_TAIL: begin
          if (step_r == TL_END) begin
            step_r  <= '0;
            state_r <= S_DONE;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    uop = '{vld: 1'b0, a_sel: mfe_pkg::A_PR, b_sel: mfe_pkg::B_CR,
            mode: mfe_pkg::ACC_LOAD, wb: mfe_pkg::WB_NONE};
    if (state_r == S_TERM) begin
      case (step_r)
        ST_SR_A: uop = '{1'b1, mfe_pkg::A_PR, mfe_pkg::B_CR, mfe_pkg::ACC_LOAD,
                         mfe_pkg::WB_NONE};
        ST_SR_B: uop = '{1'b1, mfe_pkg::A_PI, mfe_pkg::B_CI, mfe_pkg::ACC_SUB,
                         term_on ? mfe_pkg::WB_SR : mfe_pkg::WB_NONE};
        ST_SI_A: uop = '{1'b1, mfe_pkg::A_PI, mfe_pkg::B_CR, mfe_pkg::ACC_LOAD,
                         mfe_pkg::WB_NONE};
        ST_SI_B: uop = '{1'b1, mfe_pkg::A_PR, mfe_pkg::B_CI, mfe_pkg::ACC_ADD,
                         term_on ? mfe_pkg::WB_SI : mfe_pkg::WB_NONE};
        ST_PR_A: uop = '{1'b1, mfe_pkg::A_PR, mfe_pkg::B_X, mfe_pkg::ACC_LOAD,
                         mfe_pkg::WB_NONE};
        ST_PR_B: uop = '{1'b1, mfe_pkg::A_PI, mfe_pkg::B_Y, mfe_pkg::ACC_SUB,
                         mfe_pkg::WB_PR};
        ST_PI_A: uop = '{1'b1, mfe_pkg::A_PR, mfe_pkg::B_Y, mfe_pkg::ACC_LOAD,
                         mfe_pkg::WB_NONE};
        ST_PI_B: uop = '{1'b1, mfe_pkg::A_PI, mfe_pkg::B_X, mfe_pkg::ACC_ADD,
                         mfe_pkg::WB_PI};
        default: ;
      endcase
    end else if (state_r == S_TAIL) begin
      case (step_r)
        TL_BY:   uop = '{1'b1, mfe_pkg::A_SR, mfe_pkg::B_SCALE, mfe_pkg::ACC_LOAD,
                         mfe_pkg::WB_BY};
        TL_BX:   uop = '{1'b1, mfe_pkg::A_SI, mfe_pkg::B_SCALE, mfe_pkg::ACC_LOAD,
                         mfe_pkg::WB_BX};
        TL_QBY:  uop = '{1'b1, mfe_pkg::A_BY, mfe_pkg::B_Q, mfe_pkg::ACC_LOAD,
                         mfe_pkg::WB_QBY};
        TL_QBX:  uop = '{1'b1, mfe_pkg::A_BX, mfe_pkg::B_Q, mfe_pkg::ACC_LOAD,
                         mfe_pkg::WB_QBX};
        TL_FX:   uop = '{1'b1, mfe_pkg::A_QBY, mfe_pkg::B_VZ, mfe_pkg::ACC_LOAD_NEG,
                         mfe_pkg::WB_FX};
        TL_FY:   uop = '{1'b1, mfe_pkg::A_QBX, mfe_pkg::B_VZ, mfe_pkg::ACC_LOAD,
                         mfe_pkg::WB_FY};
        TL_FZ_A: uop = '{1'b1, mfe_pkg::A_QBY, mfe_pkg::B_VX, mfe_pkg::ACC_LOAD,
                         mfe_pkg::WB_NONE};
        TL_FZ_B: uop = '{1'b1, mfe_pkg::A_QBX, mfe_pkg::B_VY, mfe_pkg::ACC_SUB,
                         mfe_pkg::WB_FZ};
        default: ;
      endcase
    end
  end

  assign term_idx  = n_r;
  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_DONE);

endmodule

// ----- rtl/core/mfe_dp.sv -----
// Datapath: operand selection, the shared multiplier and accumulator, and the
// rounding and saturating write-back into the working registers. Depends on mfe_pkg.
module mfe_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  logic signed [mfe_pkg::POS_W-1:0]    pos_x,
  input  logic signed [mfe_pkg::POS_W-1:0]    pos_y,
  input  logic signed [mfe_pkg::VEL_W-1:0]    vel_x,
  input  logic signed [mfe_pkg::VEL_W-1:0]    vel_y,
  input  logic signed [mfe_pkg::VEL_W-1:0]    vel_z,
  input  logic signed [mfe_pkg::CHARGE_W-1:0] charge,
  input  logic signed [mfe_pkg::SCALE_W-1:0]  field_scale,
  input  logic [mfe_pkg::COEF_W-1:0]          coef_word,
  input  mfe_pkg::uop_t                       uop,
  output logic signed [mfe_pkg::FIELD_W-1:0]  field_x,
  output logic signed [mfe_pkg::FIELD_W-1:0]  field_y,
  output logic signed [mfe_pkg::FORCE_W-1:0]  force_x,
  output logic signed [mfe_pkg::FORCE_W-1:0]  force_y,
  output logic signed [mfe_pkg::FORCE_W-1:0]  force_z
);

  localparam int ACC_W  = mfe_pkg::ACC_W;
  localparam int POW_W  = mfe_pkg::POW_W;
  localparam int SUM_W  = mfe_pkg::SUM_W;
  localparam int QB_W   = mfe_pkg::QB_W;
  localparam int A_W    = mfe_pkg::MUL_A_W;
  localparam int B_W    = mfe_pkg::MUL_B_W;
  localparam int HALF_W = mfe_pkg::COEF_HALF_W;
  localparam logic signed [POW_W-1:0] POW_ONE = POW_W'(64'd1 << mfe_pkg::FRAC_SHIFT);

  // floor((v + 2^(k-1)) / 2^k)
  function automatic logic signed [ACC_W-1:0] round_shift(
    input logic signed [ACC_W-1:0] v, input int unsigned k);
    logic signed [ACC_W-1:0] half;
    half = ACC_W'(1) << (k - 1);
    return (v + half) >>> k;
  endfunction

  // Clamp to the signed range of w bits, kept at full width.
  function automatic logic signed [ACC_W-1:0] sat_to(
    input logic signed [ACC_W-1:0] v, input int unsigned w);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = (ACC_W'(1) << (w - 1)) - ACC_W'(1);
    lo = ~hi;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  logic signed [mfe_pkg::POS_W-1:0]    x_r, y_r;
  logic signed [mfe_pkg::VEL_W-1:0]    vx_r, vy_r, vz_r;
  logic signed [mfe_pkg::CHARGE_W-1:0] q_r;
  logic signed [POW_W-1:0]             pr_r, pi_r;
  logic signed [SUM_W-1:0]             sr_r, si_r;
  logic signed [mfe_pkg::FIELD_W-1:0]  by_r, bx_r;
  logic signed [QB_W-1:0]              qby_r, qbx_r;
  logic signed [mfe_pkg::FORCE_W-1:0]  fx_r, fy_r, fz_r;

  logic signed [HALF_W-1:0]            cr, ci;
  logic signed [ACC_W-1:0]             sr_sat_w, si_sat_w;
  logic signed [mfe_pkg::FIELD_W-1:0]  sr_sat, si_sat;
  logic signed [A_W-1:0]               op_a;
  logic signed [B_W-1:0]               op_b;

  logic signed [mfe_pkg::PROD_W-1:0]   mul_r;
  logic signed [ACC_W-1:0]             acc_r;
  logic signed [ACC_W-1:0]             mul_ext;
  logic                                v1_r, v2_r;
  mfe_pkg::acc_mode_t                  mode1_r;
  mfe_pkg::wb_t                        wb1_r, wb2_r;

  logic signed [ACC_W-1:0]             r_frac, r_chg, r_vel;
  logic signed [ACC_W-1:0]             s_pow, s_fld, s_frc;

  assign cr = coef_word[2*HALF_W-1:HALF_W];
  assign ci = coef_word[HALF_W-1:0];

  always_comb begin
    sr_sat_w = sat_to(ACC_W'(sr_r), mfe_pkg::FIELD_W);
    si_sat_w = sat_to(ACC_W'(si_r), mfe_pkg::FIELD_W);
    sr_sat   = sr_sat_w[mfe_pkg::FIELD_W-1:0];
    si_sat   = si_sat_w[mfe_pkg::FIELD_W-1:0];
  end

  always_comb begin
    case (uop.a_sel)
      mfe_pkg::A_PR:  op_a = pr_r;
      mfe_pkg::A_PI:  op_a = pi_r;
      mfe_pkg::A_SR:  op_a = A_W'(sr_sat);
      mfe_pkg::A_SI:  op_a = A_W'(si_sat);
      mfe_pkg::A_BY:  op_a = A_W'(by_r);
      mfe_pkg::A_BX:  op_a = A_W'(bx_r);
      mfe_pkg::A_QBY: op_a = A_W'(qby_r);
      mfe_pkg::A_QBX: op_a = A_W'(qbx_r);
      default:        op_a = '0;
    endcase
  end

  always_comb begin
    case (uop.b_sel)
      mfe_pkg::B_CR:    op_b = B_W'(cr);
      mfe_pkg::B_CI:    op_b = B_W'(ci);
      mfe_pkg::B_X:     op_b = B_W'(x_r);
      mfe_pkg::B_Y:     op_b = B_W'(y_r);
      mfe_pkg::B_SCALE: op_b = B_W'(field_scale);
      mfe_pkg::B_Q:     op_b = B_W'(q_r);
      mfe_pkg::B_VX:    op_b = B_W'(vx_r);
      mfe_pkg::B_VY:    op_b = B_W'(vy_r);
      mfe_pkg::B_VZ:    op_b = B_W'(vz_r);
      default:          op_b = '0;
    endcase
  end

  assign mul_ext = ACC_W'(mul_r);

  always_comb begin
    r_frac = round_shift(acc_r, mfe_pkg::FRAC_SHIFT);
    r_chg  = round_shift(acc_r, mfe_pkg::CHARGE_SHIFT);
    r_vel  = round_shift(acc_r, mfe_pkg::VEL_SHIFT);
    s_pow  = sat_to(r_frac, POW_W);
    s_fld  = sat_to(r_frac, mfe_pkg::FIELD_W);
    s_frc  = sat_to(r_vel, mfe_pkg::FORCE_W);
  end

  // Pipeline control: issue, accumulate, write back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= uop.vld;
      v2_r <= v1_r && (wb1_r != mfe_pkg::WB_NONE);
    end
  end

  always_ff @(posedge clk) begin
    mul_r   <= op_a * op_b;
    mode1_r <= uop.mode;
    wb1_r   <= uop.wb;
    wb2_r   <= wb1_r;
    if (v1_r) begin
      case (mode1_r)
        mfe_pkg::ACC_LOAD:     acc_r <= mul_ext;
        mfe_pkg::ACC_LOAD_NEG: acc_r <= -mul_ext;
        mfe_pkg::ACC_ADD:      acc_r <= acc_r + mul_ext;
        mfe_pkg::ACC_SUB:      acc_r <= acc_r - mul_ext;
        default:               acc_r <= mul_ext;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r  <= pos_x;
      y_r  <= pos_y;
      vx_r <= vel_x;
      vy_r <= vel_y;
      vz_r <= vel_z;
      q_r  <= charge;
      pr_r <= POW_ONE;
      pi_r <= '0;
      sr_r <= '0;
      si_r <= '0;
    end else if (v2_r) begin
      case (wb2_r)
        mfe_pkg::WB_SR:  sr_r  <= sr_r + r_frac[SUM_W-1:0];
        mfe_pkg::WB_SI:  si_r  <= si_r + r_frac[SUM_W-1:0];
        mfe_pkg::WB_PR:  pr_r  <= s_pow[POW_W-1:0];
        mfe_pkg::WB_PI:  pi_r  <= s_pow[POW_W-1:0];
        mfe_pkg::WB_BY:  by_r  <= s_fld[mfe_pkg::FIELD_W-1:0];
        mfe_pkg::WB_BX:  bx_r  <= s_fld[mfe_pkg::FIELD_W-1:0];
        mfe_pkg::WB_QBY: qby_r <= r_chg[QB_W-1:0];
        mfe_pkg::WB_QBX: qbx_r <= r_chg[QB_W-1:0];
        mfe_pkg::WB_FX:  fx_r  <= s_frc[mfe_pkg::FORCE_W-1:0];
        mfe_pkg::WB_FY:  fy_r  <= s_frc[mfe_pkg::FORCE_W-1:0];
        mfe_pkg::WB_FZ:  fz_r  <= s_frc[mfe_pkg::FORCE_W-1:0];
        default: ;
      endcase
    end
  end

  assign field_x = bx_r;
  assign field_y = by_r;
  assign force_x = fx_r;
  assign force_y = fy_r;
  assign force_z = fz_r;

endmodule

// ----- rtl/core/mfe_checker.sv -----
// Port-level assertions for the multipole field and force evaluator, bound to the top.
// Depends on mfe_pkg and multipole_field_and_force_eval.
module mfe_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [mfe_pkg::FIELD_W-1:0]  out_field_x,
  input logic signed [mfe_pkg::FIELD_W-1:0]  out_field_y,
  input logic signed [mfe_pkg::FORCE_W-1:0]  out_force_x,
  input logic signed [mfe_pkg::FORCE_W-1:0]  out_force_y,
  input logic signed [mfe_pkg::FORCE_W-1:0]  out_force_z
);

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_field_x) && $stable(out_field_y)
      && $stable(out_force_x) && $stable(out_force_y) && $stable(out_force_z))
    else $error("stalled result word changed");

  // After taking a word the block is busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in progress");

  // A fresh result releases the input side at once.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("input still stalled after result was posted");

  // No vertical field component means no horizontal force.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_field_y == '0) |-> (out_force_x == '0))
    else $error("force_x nonzero with zero field_y");

  // No horizontal field component means no vertical force.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_field_x == '0) |-> (out_force_y == '0))
    else $error("force_y nonzero with zero field_x");

endmodule

bind multipole_field_and_force_eval mfe_checker u_mfe_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_field_x (out_field_x),
  .out_field_y (out_field_y),
  .out_force_x (out_force_x),
  .out_force_y (out_force_y),
  .out_force_z (out_force_z)
);

// ----- sim/multipole_field_and_force_eval_tb.sv -----
// Self-checking testbench for multipole_field_and_force_eval: a directed table, then
// random words under three idling patterns, each checked against a fixed-point predictor.
// Depends on rtl/core/mfe_pkg.sv and rtl/core/multipole_field_and_force_eval.sv.
`timescale 1ns / 100ps

module multipole_field_and_force_eval_tb;

  localparam int MAX_TERMS = mfe_pkg::MAX_TERMS_DEF;
  localparam int N_DIR     = 20;

  // Directed coefficient patterns: real half in the upper 24 bits.
  localparam logic [mfe_pkg::COEF_W-1:0] C_UNIT = {24'h200000, 24'h000000};
  localparam logic [mfe_pkg::COEF_W-1:0] C_MAX  = {24'h7FFFFF, 24'h7FFFFF};
  localparam logic [mfe_pkg::COEF_W-1:0] C_MIN  = {24'h800000, 24'h800000};
  localparam logic [mfe_pkg::COEF_W-1:0] C_MIX  = {24'h100000, 24'hF00000};

  typedef struct {
    logic signed [mfe_pkg::POS_W-1:0]    pos_x;
    logic signed [mfe_pkg::POS_W-1:0]    pos_y;
    logic signed [mfe_pkg::DROP_W-1:0]   drop;
    logic signed [mfe_pkg::VEL_W-1:0]    vel_x;
    logic signed [mfe_pkg::VEL_W-1:0]    vel_y;
    logic signed [mfe_pkg::VEL_W-1:0]    vel_z;
    logic signed [mfe_pkg::CHARGE_W-1:0] charge;
  } particle_t;

  typedef struct {
    logic signed [mfe_pkg::FIELD_W-1:0] field_x;
    logic signed [mfe_pkg::FIELD_W-1:0] field_y;
    logic signed [mfe_pkg::FORCE_W-1:0] force_x;
    logic signed [mfe_pkg::FORCE_W-1:0] force_y;
    logic signed [mfe_pkg::FORCE_W-1:0] force_z;
  } field_force_t;

  typedef struct {
    bit                                   reconf;
    logic [mfe_pkg::SCALE_W-1:0]          scale;
    logic [mfe_pkg::TERMS_W-1:0]          terms;
    logic [mfe_pkg::COEF_W-1:0]           coef;
    bit                                   zero_exp;
    logic signed [mfe_pkg::POS_W-1:0]     pos_x;
    logic signed [mfe_pkg::POS_W-1:0]     pos_y;
    logic signed [mfe_pkg::DROP_W-1:0]    drop;
    logic signed [mfe_pkg::VEL_W-1:0]     vel_x;
    logic signed [mfe_pkg::VEL_W-1:0]     vel_y;
    logic signed [mfe_pkg::VEL_W-1:0]     vel_z;
    logic signed [mfe_pkg::CHARGE_W-1:0]  charge;
  } dir_row_t;

  // reconf, scale, terms, coef, zero, pos_x, pos_y, drop, vel_x, vel_y, vel_z, charge
  dir_row_t dir_table [N_DIR] = '{
    '{1'b0, 32'h00000000, 3'd0, C_UNIT, 1'b1, 24'h7FFFFF, 24'h7FFFFF, -4'sd1,
      24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h7FFF},
    '{1'b1, 32'h00000000, 3'd6, C_MAX, 1'b1, 24'h100000, 24'h080000, -4'sd1,
      24'h400000, 24'h400000, 24'h400000, 16'h4000},
    '{1'b1, 32'h00800000, 3'd6, C_UNIT, 1'b0, 24'h100000, 24'h000000, -4'sd1,
      24'h000000, 24'h000000, 24'h400000, 16'h4000},
    '{1'b0, 32'h00800000, 3'd6, C_UNIT, 1'b0, 24'h100000, 24'h100000, -4'sd1,
      24'h200000, 24'hE00000, 24'h400000, 16'hC000},
    '{1'b0, 32'h00800000, 3'd6, C_UNIT, 1'b0, 24'h7FFFFF, 24'h7FFFFF, -4'sd1,
      24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h7FFF},
    '{1'b0, 32'h00800000, 3'd6, C_UNIT, 1'b0, 24'h800000, 24'h800000, -4'sd1,
      24'h800000, 24'h800000, 24'h800000, 16'h8000},
    '{1'b0, 32'h00800000, 3'd6, C_UNIT, 1'b0, 24'h180000, 24'hF00000, 4'sb1000,
      24'h123456, 24'hFEDCBA, 24'h0ABCDE, 16'h2000},
    '{1'b0, 32'h00800000, 3'd6, C_UNIT, 1'b0, 24'h180000, 24'hF00000, 4'sd4,
      24'h123456, 24'hFEDCBA, 24'h0ABCDE, 16'h2000},
    '{1'b0, 32'h00800000, 3'd6, C_UNIT, 1'b1, 24'h180000, 24'hF00000, 4'sd5,
      24'h123456, 24'hFEDCBA, 24'h0ABCDE, 16'h2000},
    '{1'b0, 32'h00800000, 3'd6, C_UNIT, 1'b1, 24'h180000, 24'hF00000, 4'sd7,
      24'h123456, 24'hFEDCBA, 24'h0ABCDE, 16'h2000},
    '{1'b1, 32'h00800000, 3'd7, C_MIX, 1'b0, 24'h100000, 24'h100000, -4'sd1,
      24'h300000, 24'hD00000, 24'h200000, 16'h4000},
    '{1'b1, 32'h00800000, 3'd0, C_MIX, 1'b1, 24'h100000, 24'h100000, -4'sd1,
      24'h300000, 24'hD00000, 24'h200000, 16'h4000},
    '{1'b1, 32'h7FFFFFFF, 3'd6, C_MAX, 1'b0, 24'h7FFFFF, 24'h7FFFFF, -4'sd1,
      24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'h7FFF},
    '{1'b0, 32'h7FFFFFFF, 3'd6, C_MAX, 1'b0, 24'h800000, 24'h7FFFFF, -4'sd1,
      24'h800000, 24'h7FFFFF, 24'h800000, 16'h8000},
    '{1'b1, 32'h80000000, 3'd6, C_MIN, 1'b0, 24'h7FFFFF, 24'h800000, -4'sd1,
      24'h7FFFFF, 24'h7FFFFF, 24'h800000, 16'h7FFF},
    '{1'b0, 32'h80000000, 3'd6, C_MIN, 1'b0, 24'h400000, 24'h400000, 4'sd2,
      24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h0000},
    '{1'b1, 32'h00C00000, 3'd1, C_MIX, 1'b0, 24'h300000, 24'hD00000, -4'sd1,
      24'h100000, 24'hF00000, 24'h080000, 16'h3000},
    '{1'b0, 32'h00C00000, 3'd1, C_MIX, 1'b1, 24'h300000, 24'hD00000, 4'sd0,
      24'h100000, 24'hF00000, 24'h080000, 16'h3000},
    '{1'b1, 32'hFFFFFFFF, 3'd3, C_UNIT, 1'b0, 24'h200000, 24'h200000, -4'sd1,
      24'h7FFFFF, 24'h000001, 24'h7FFFFF, 16'h7FFF},
    '{1'b0, 32'hFFFFFFFF, 3'd3, C_UNIT, 1'b0, 24'h000000, 24'h000000, -4'sd1,
      24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'h8000}
  };

  logic                                clk             = 1'b0;
  logic                                rst_n           = 1'b0;
  logic                                cfg_we          = 1'b0;
  logic [mfe_pkg::CFG_IDX_W-1:0]       cfg_index       = '0;
  logic [mfe_pkg::CFG_DATA_W-1:0]      cfg_data        = '0;
  logic                                in_valid        = 1'b0;
  logic                                in_stall;
  logic signed [mfe_pkg::POS_W-1:0]    in_pos_x        = '0;
  logic signed [mfe_pkg::POS_W-1:0]    in_pos_y        = '0;
  logic signed [mfe_pkg::DROP_W-1:0]   in_drop_through = '0;
  logic signed [mfe_pkg::VEL_W-1:0]    in_vel_x        = '0;
  logic signed [mfe_pkg::VEL_W-1:0]    in_vel_y        = '0;
  logic signed [mfe_pkg::VEL_W-1:0]    in_vel_z        = '0;
  logic signed [mfe_pkg::CHARGE_W-1:0] in_charge       = '0;
  logic                                out_valid;
  logic                                out_stall       = 1'b0;
  logic signed [mfe_pkg::FIELD_W-1:0]  out_field_x;
  logic signed [mfe_pkg::FIELD_W-1:0]  out_field_y;
  logic signed [mfe_pkg::FORCE_W-1:0]  out_force_x;
  logic signed [mfe_pkg::FORCE_W-1:0]  out_force_y;
  logic signed [mfe_pkg::FORCE_W-1:0]  out_force_z;

  // Shadow of the block's registers.
  longint                      scale_reg = 0;
  logic [mfe_pkg::TERMS_W-1:0] terms_reg = 3'd1;
  longint                      coef_re [MAX_TERMS];
  longint                      coef_im [MAX_TERMS];

  field_force_t pending_results [$];
  int           err_count     = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;

  multipole_field_and_force_eval dut (.*);

  always #5 clk = ~clk;

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  function automatic longint round_shift(input longint v, input int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic longint clamp(input longint v, input int w);
    longint hi;
    hi = (longint'(1) << (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic field_force_t eval_field_force(input particle_t p);
    longint x, y, drop, vx, vy, vz, q, terms, start;
    longint pr, pi, sr, si, nr, ni, bx, by, qbx, qby;
    field_force_t r;
    x = longint'(p.pos_x);
    y = longint'(p.pos_y);
    drop = longint'(p.drop);
    vx = longint'(p.vel_x);
    vy = longint'(p.vel_y);
    vz = longint'(p.vel_z);
    q = longint'(p.charge);
    terms = longint'(terms_reg);
    if (terms > MAX_TERMS) terms = longint'(MAX_TERMS);
    if (drop < -1) drop = -longint'(1);
    start = drop + 1;
    bx = 0;
    by = 0;
    if (scale_reg != 0 && start < terms) begin
      pr = longint'(1) << mfe_pkg::FRAC_SHIFT;
      pi = 0;
      sr = 0;
      si = 0;
      // Walk the powers of z, summing only the terms past the drop index.
      for (int n = 0; n < terms; n++) begin
        if (n >= start) begin
          sr += round_shift(coef_re[n] * pr - coef_im[n] * pi, mfe_pkg::FRAC_SHIFT);
          si += round_shift(coef_re[n] * pi + coef_im[n] * pr, mfe_pkg::FRAC_SHIFT);
        end
        nr = round_shift(pr * x - pi * y, mfe_pkg::FRAC_SHIFT);
        ni = round_shift(pr * y + pi * x, mfe_pkg::FRAC_SHIFT);
        pr = clamp(nr, mfe_pkg::POW_W);
        pi = clamp(ni, mfe_pkg::POW_W);
      end
      sr = clamp(sr, 32);
      si = clamp(si, 32);
      by = clamp(round_shift(sr * scale_reg, mfe_pkg::FRAC_SHIFT), mfe_pkg::FIELD_W);
      bx = clamp(round_shift(si * scale_reg, mfe_pkg::FRAC_SHIFT), mfe_pkg::FIELD_W);
    end
    qbx = round_shift(q * bx, mfe_pkg::CHARGE_SHIFT);
    qby = round_shift(q * by, mfe_pkg::CHARGE_SHIFT);
    r.field_x = mfe_pkg::FIELD_W'(bx);
    r.field_y = mfe_pkg::FIELD_W'(by);
    r.force_x = mfe_pkg::FORCE_W'(clamp(round_shift(-(qby * vz), mfe_pkg::VEL_SHIFT),
                                        mfe_pkg::FORCE_W));
    r.force_y = mfe_pkg::FORCE_W'(clamp(round_shift(qbx * vz, mfe_pkg::VEL_SHIFT),
                                        mfe_pkg::FORCE_W));
    r.force_z = mfe_pkg::FORCE_W'(clamp(round_shift(qby * vx - qbx * vy, mfe_pkg::VEL_SHIFT),
                                        mfe_pkg::FORCE_W));
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    field_force_t want;
    if (out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation pending");
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("field_x", longint'(want.field_x), longint'(out_field_x));
        check_field("field_y", longint'(want.field_y), longint'(out_field_y));
        check_field("force_x", longint'(want.force_x), longint'(out_force_x));
        check_field("force_y", longint'(want.force_y), longint'(out_force_y));
        check_field("force_z", longint'(want.force_z), longint'(out_force_z));
      end
    end
  end

  // One word per call; valid is assigned at most once at each falling edge.
  task automatic send_word(input particle_t p, input bit zero_exp);
    field_force_t zero_r;
    zero_r = '{default: 0};
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_pos_x        <= p.pos_x;
    in_pos_y        <= p.pos_y;
    in_drop_through <= p.drop;
    in_vel_x        <= p.vel_x;
    in_vel_y        <= p.vel_y;
    in_vel_z        <= p.vel_z;
    in_charge       <= p.charge;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(zero_exp ? zero_r : eval_field_force(p));
  endtask

  // Called right after an accepted word: drops valid and waits for the block to drain.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mfe_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [mfe_pkg::CFG_DATA_W-1:0] data);
    int n;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    n = int'(idx) - mfe_pkg::REG_COEF_0;
    if (idx == mfe_pkg::REG_FIELD_SCALE) begin
      scale_reg = longint'($signed(data[mfe_pkg::SCALE_W-1:0]));
    end else if (idx == mfe_pkg::REG_TERMS) begin
      terms_reg = data[mfe_pkg::TERMS_W-1:0];
    end else if (n >= 0 && n < mfe_pkg::NUM_COEF_REGS && n < MAX_TERMS) begin
      coef_re[n] = longint'($signed(data[mfe_pkg::COEF_W-1:mfe_pkg::COEF_HALF_W]));
      coef_im[n] = longint'($signed(data[mfe_pkg::COEF_HALF_W-1:0]));
    end
  endtask

  task automatic configure(input logic [mfe_pkg::CFG_DATA_W-1:0] scale_w,
                           input logic [mfe_pkg::CFG_DATA_W-1:0] terms_w,
                           input logic [mfe_pkg::COEF_W-1:0] coefs [mfe_pkg::NUM_COEF_REGS],
                           input bit stray);
    write_reg(mfe_pkg::REG_FIELD_SCALE, scale_w);
    write_reg(mfe_pkg::REG_TERMS, terms_w);
    for (int i = 0; i < mfe_pkg::NUM_COEF_REGS; i++) begin
      write_reg(mfe_pkg::CFG_IDX_W'(mfe_pkg::REG_COEF_0 + i), coefs[i]);
    end
    // Indexes past the coefficient bank must leave every register alone.
    if (stray) begin
      write_reg(mfe_pkg::CFG_IDX_W'($urandom_range(2**mfe_pkg::CFG_IDX_W - 1,
                                                   mfe_pkg::REG_COEF_0 +
                                                   mfe_pkg::NUM_COEF_REGS)),
                mfe_pkg::CFG_DATA_W'({$urandom, $urandom}));
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [23:0] pick24(input int mode);
    logic signed [23:0] v;
    v = 24'($urandom);
    case (mode)
      0, 1, 2, 3, 4: v = v >>> $urandom_range(4, 1);
      8, 9: begin
        case ($urandom_range(3))
          0: v = 24'h7FFFFF;
          1: v = 24'h800000;
          2: v = 24'h000000;
          default: v = 24'h200000;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic particle_t random_particle();
    particle_t p;
    p.pos_x = pick24(int'($urandom_range(9)));
    p.pos_y = pick24(int'($urandom_range(9)));
    case ($urandom_range(3))
      1: p.drop = mfe_pkg::DROP_W'($urandom);
      2: p.drop = mfe_pkg::DROP_W'($urandom_range(2));
      default: p.drop = -4'sd1;
    endcase
    p.vel_x = pick24(int'($urandom_range(9, 5)));
    p.vel_y = pick24(int'($urandom_range(9, 5)));
    p.vel_z = pick24(int'($urandom_range(9, 5)));
    if ($urandom_range(4) == 0) p.charge = $urandom_range(1) ? 16'h7FFF : 16'h8000;
    else p.charge = mfe_pkg::CHARGE_W'($urandom);
    return p;
  endfunction

  task automatic random_config();
    logic signed [mfe_pkg::SCALE_W-1:0] scale;
    logic [mfe_pkg::CFG_DATA_W-1:0]     terms_w;
    logic signed [23:0]                 re, im;
    logic [mfe_pkg::COEF_W-1:0]         coefs [mfe_pkg::NUM_COEF_REGS];
    scale = $urandom;
    case ($urandom_range(7))
      0: scale = '0;
      1: scale = 32'h7FFFFFFF;
      2: scale = 32'h80000000;
      3, 4: scale = scale >>> $urandom_range(12, 4);
      default: ;
    endcase
    terms_w = mfe_pkg::CFG_DATA_W'({$urandom, $urandom});
    if ($urandom_range(9) == 0) begin
      terms_w[mfe_pkg::TERMS_W-1:0] = $urandom_range(1) ? 3'd0 : 3'd7;
    end else begin
      terms_w[mfe_pkg::TERMS_W-1:0] = mfe_pkg::TERMS_W'($urandom_range(MAX_TERMS, 1));
    end
    for (int i = 0; i < mfe_pkg::NUM_COEF_REGS; i++) begin
      re = 24'($urandom);
      im = 24'($urandom);
      case ($urandom_range(5))
        0: begin
          re = '0;
          im = '0;
        end
        1: begin
          re = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
          im = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
        end
        2, 3: begin
          re = re >>> $urandom_range(6);
          im = im >>> $urandom_range(6);
        end
        default: ;
      endcase
      coefs[i] = {re, im};
    end
    configure({16'($urandom), scale}, terms_w, coefs, 1'($urandom_range(1)));
  endtask

  initial begin
    int send_pct [3];
    int recv_pct [3];
    particle_t p;
    logic [mfe_pkg::COEF_W-1:0] coefs [mfe_pkg::NUM_COEF_REGS];
    send_pct = '{11, 55, 0};
    recv_pct = '{55, 11, 0};
    foreach (coef_re[i]) begin
      coef_re[i] = 0;
      coef_im[i] = 0;
    end
    send_idle_pct = send_pct[0];
    recv_idle_pct = recv_pct[0];
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      if (dir_table[i].reconf) begin
        settle();
        foreach (coefs[k]) coefs[k] = dir_table[i].coef;
        configure({16'h0, dir_table[i].scale}, {45'h0, dir_table[i].terms}, coefs, 1'b0);
      end
      p.pos_x  = dir_table[i].pos_x;
      p.pos_y  = dir_table[i].pos_y;
      p.drop   = dir_table[i].drop;
      p.vel_x  = dir_table[i].vel_x;
      p.vel_y  = dir_table[i].vel_y;
      p.vel_z  = dir_table[i].vel_z;
      p.charge = dir_table[i].charge;
      send_word(p, dir_table[i].zero_exp);
    end

    // Registers change only once the block has gone quiet, so the sender
    // pauses for every outstanding result before each new setting.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = send_pct[ph];
      recv_idle_pct = recv_pct[ph];
      for (int s = 0; s < 4; s++) begin
        settle();
        random_config();
        for (int i = 0; i < 54; i++) send_word(random_particle(), 1'b0);
      end
    end

    settle();
    repeat (10 * MAX_TERMS + 20) @(posedge clk);
    if (err_count == 0) begin
      $display("multipole_field_and_force_eval test passed");
    end else begin
      $display("multipole_field_and_force_eval test failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("multipole_field_and_force_eval test failed");
    $finish;
  end

endmodule
